// ----- hw/rtl/est_pkg.sv -----
package est_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int SLOTS_PER_BLOCK = 8;
  localparam int HEADER_WORDS    = 2;
  localparam int BLOCK_STRIDE    = SLOTS_PER_BLOCK + HEADER_WORDS;
  localparam int QUEUE_DEPTH     = 2;

  // reciprocal of the block stride for handles below 128
  localparam int RECIP_MUL   = 205;
  localparam int RECIP_SHIFT = 11;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_FILTER = 3'd4;
  localparam logic [2:0] CMD_FIND   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  orient;
    logic [6:0]  handle;
    logic [6:0]  idx;
    logic        hdr_ok;
    logic [63:0] ptr;
    logic [7:0]  label;
    logic [6:0]  limit;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DISPATCH, B_RD, B_EV, B_SCAN_RD, B_SCAN_EV, B_SCAN_END
  } back_state_t;

  function automatic logic [6:0] handle_of(logic [6:0] s);
    logic [6:0] h;
    h = 7'(s[6:3]) * 7'(BLOCK_STRIDE) + 7'(s[2:0]) + 7'(HEADER_WORDS);
    return h;
  endfunction

endpackage

// ----- hw/rtl/est_front.sv -----
module est_front import est_pkg::*; (
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  cmd,
  input  logic [2:0]  orientation,
  input  logic [6:0]  slot_handle,
  input  logic [63:0] pointer,
  input  logic [7:0]  label,
  input  logic [6:0]  result_limit,
  output logic        push,
  output item_t       item
);

  logic [14:0] prod;
  logic [3:0]  blk;
  logic [6:0]  rem;

  // handle split into block and word by reciprocal multiply
  always_comb begin
    prod = 15'(slot_handle) * 15'(RECIP_MUL);
    blk  = prod[14:RECIP_SHIFT];
    rem  = slot_handle - 7'(blk) * 7'(BLOCK_STRIDE);
  end

  always_comb begin
    item.cmd    = cmd;
    item.orient = orientation;
    item.handle = slot_handle;
    item.hdr_ok = rem >= 7'(HEADER_WORDS);
    item.idx    = {blk[3:0], 3'b000} + rem - 7'(HEADER_WORDS);
    item.ptr    = pointer;
    item.label  = label;
    item.limit  = result_limit;
  end

  // unused command codes are dropped here
  assign push = start && !busy && (cmd <= CMD_FIND);

endmodule

// ----- hw/rtl/est_queue.sv -----
module est_queue import est_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item,
  output logic  full
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         ent [QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign q_valid = count != '0;
  assign full    = count == CW'(QUEUE_DEPTH);
  assign q_item  = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- hw/rtl/est_back.sv -----
module est_back import est_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        valid,
  output logic [6:0]  offset,
  output logic        found,
  output logic [1:0]  orientation_out,
  output logic [63:0] pointer_out,
  output logic [7:0]  label_out,
  output logic [6:0]  match_count,
  output logic [1:0]  status,
  output logic        last
);

  localparam int IW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);

  logic [1:0]  dir_mem [SLOTS];
  logic [7:0]  lab_mem [SLOTS];
  logic [63:0] tgt_mem [SLOTS];

  back_state_t state, state_next;
  item_t       cur;
  logic [FW-1:0] fill;
  logic [IW-1:0] scan_i;
  logic [6:0]    emitted;
  logic          pend_valid;
  logic [6:0]    pend_offset;
  logic          trunc;

  logic [IW-1:0] rd_addr;
  logic [1:0]    rd_dir;
  logic [7:0]    rd_lab;
  logic [63:0]   rd_tgt;

  logic slot_ok, filt_hit, find_hit, scan_last, at_limit;
  logic [1:0] want;

  logic        emit;
  logic [6:0]  e_offset;
  logic        e_found;
  logic [1:0]  e_orient;
  logic [63:0] e_ptr;
  logic [7:0]  e_label;
  logic [6:0]  e_count;
  logic [1:0]  e_status;
  logic        e_last;
  logic        add_we, dir_clr, lab_we;

  assign rd_addr   = (state == B_SCAN_RD) ? scan_i : cur.idx[IW-1:0];
  assign slot_ok   = cur.hdr_ok && (cur.idx < 7'(fill));
  assign want      = {cur.orient[0], cur.orient[1]};
  assign filt_hit  = (cur.orient & {1'b0, rd_dir}) != 3'd0;
  assign find_hit  = ((want & rd_dir) != 2'd0) && (rd_tgt == cur.ptr) &&
                     (rd_lab == cur.label);
  assign scan_last = (FW'(scan_i) + FW'(1)) == fill;
  assign at_limit  = emitted >= cur.limit;

  always_ff @(posedge clk) begin
    rd_dir <= dir_mem[rd_addr];
    rd_lab <= lab_mem[rd_addr];
    rd_tgt <= tgt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (add_we) begin
      dir_mem[fill[IW-1:0]] <= cur.orient[1:0];
      lab_mem[fill[IW-1:0]] <= '0;
      tgt_mem[fill[IW-1:0]] <= cur.ptr;
    end else if (dir_clr) begin
      dir_mem[cur.idx[IW-1:0]] <= '0;
    end else if (lab_we) begin
      lab_mem[cur.idx[IW-1:0]] <= cur.label;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:     if (q_valid) state_next = B_DISPATCH;
      B_DISPATCH: begin
        case (cur.cmd)
          CMD_ADD:              state_next = B_IDLE;
          CMD_FILTER, CMD_FIND: state_next = (fill == '0) ? B_SCAN_END : B_SCAN_RD;
          default:              state_next = slot_ok ? B_RD : B_IDLE;
        endcase
      end
      B_RD:      state_next = B_EV;
      B_EV:      state_next = B_IDLE;
      B_SCAN_RD: state_next = B_SCAN_EV;
      B_SCAN_EV: begin
        if (cur.cmd == CMD_FILTER && filt_hit && at_limit) begin
          state_next = B_SCAN_END;
        end else if (cur.cmd == CMD_FIND && find_hit) begin
          state_next = B_IDLE;
        end else begin
          state_next = scan_last ? B_SCAN_END : B_SCAN_RD;
        end
      end
      B_SCAN_END: state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    emit     = 1'b0;
    e_offset = '0;
    e_found  = 1'b0;
    e_orient = '0;
    e_ptr    = '0;
    e_label  = '0;
    e_count  = '0;
    e_status = ST_OK;
    e_last   = 1'b0;
    add_we   = 1'b0;
    dir_clr  = 1'b0;
    lab_we   = 1'b0;
    case (state)
      B_IDLE: pop = q_valid;
      B_DISPATCH: begin
        if (cur.cmd == CMD_ADD) begin
          emit = 1'b1;
          if (fill >= FW'(SLOTS)) begin
            e_status = ST_FULL;
          end else begin
            e_offset = handle_of(7'(fill));
            e_found  = 1'b1;
            add_we   = 1'b1;
          end
        end else if (cur.cmd != CMD_FILTER && cur.cmd != CMD_FIND && !slot_ok) begin
          emit     = 1'b1;
          e_offset = cur.handle;
          e_status = ST_BAD;
        end
      end
      B_EV: begin
        emit     = 1'b1;
        e_offset = cur.handle;
        if (rd_dir != 2'd0) begin
          e_found = 1'b1;
          case (cur.cmd)
            CMD_REMOVE: dir_clr = 1'b1;
            CMD_GET: begin
              e_orient = rd_dir;
              e_ptr    = rd_tgt;
              e_label  = rd_lab;
            end
            default: lab_we = 1'b1;
          endcase
        end
      end
      B_SCAN_EV: begin
        if (cur.cmd == CMD_FILTER) begin
          if (filt_hit && !at_limit && pend_valid) begin
            emit     = 1'b1;
            e_offset = pend_offset;
            e_found  = 1'b1;
            e_count  = emitted;
          end
        end else if (find_hit) begin
          emit     = 1'b1;
          e_offset = handle_of(7'(scan_i));
          e_found  = 1'b1;
        end
      end
      B_SCAN_END: begin
        emit = 1'b1;
        if (cur.cmd == CMD_FILTER) begin
          e_last   = 1'b1;
          e_status = trunc ? ST_TRUNC : ST_OK;
          if (pend_valid) begin
            e_offset = pend_offset;
            e_found  = 1'b1;
            e_count  = emitted;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      fill       <= '0;
      valid      <= 1'b0;
      pend_valid <= 1'b0;
      trunc      <= 1'b0;
      emitted    <= '0;
      scan_i     <= '0;
    end else begin
      state <= state_next;
      valid <= emit;
      if (add_we) begin
        fill <= fill + FW'(1);
      end
      if (state == B_DISPATCH) begin
        scan_i     <= '0;
        emitted    <= '0;
        pend_valid <= 1'b0;
        trunc      <= 1'b0;
      end else if (state == B_SCAN_EV) begin
        scan_i <= scan_i + IW'(1);
        if (cur.cmd == CMD_FILTER && filt_hit) begin
          if (at_limit) begin
            trunc <= 1'b1;
          end else begin
            pend_valid  <= 1'b1;
            pend_offset <= handle_of(7'(scan_i));
            emitted     <= emitted + 7'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    offset          <= e_offset;
    found           <= e_found;
    orientation_out <= e_orient;
    pointer_out     <= e_ptr;
    label_out       <= e_label;
    match_count     <= e_count;
    status          <= e_status;
    last            <= e_last;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(SLOTS)) else $error("fill count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_FULL |-> fill == FW'(SLOTS))
    else $error("table full reported with free slots");

  a_filter_rank: assert property (@(posedge clk) disable iff (rst)
    valid && found && cur.cmd == CMD_FILTER |->
      match_count != 7'd0 && match_count <= cur.limit)
    else $error("filter rank out of range");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (rst)
    state == B_SCAN_EV |-> FW'(scan_i) < fill)
    else $error("scan past appended slots");

endmodule

// ----- hw/rtl/edge_slot_table.sv -----
// edge_slot_table: append-only edge table of one vertex. start with busy low transfers a
// command (add, remove, get, set_label, filter, find); codes 6 and 7 are dropped silently.
// Commands enter a two-entry queue, so busy rises only when two commands wait. Each result
// is shown for exactly one cycle with valid high and must be taken then: the receiver cannot
// stall. Add and bad handles are answered from the dispatch state; remove/get/set_label
// take one registered memory read, then evaluate. Filter and find walk the appended slots,
// a read state and an evaluate state per slot, through the single read port; filter gives
// one result per match up to the limit, the final one marked by last. No clearing pass after
// reset: the fill count bounds every read.
module edge_slot_table import est_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [2:0]  orientation,
  input  logic [6:0]  slot_handle,
  input  logic [63:0] pointer,
  input  logic [7:0]  label,
  input  logic [6:0]  result_limit,
  output logic        valid,
  output logic [6:0]  offset,
  output logic        found,
  output logic [1:0]  orientation_out,
  output logic [63:0] pointer_out,
  output logic [7:0]  label_out,
  output logic [6:0]  match_count,
  output logic [1:0]  status,
  output logic        last
);

  // decoded command between front and queue, queue and back
  item_t push_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_valid;

  // front: split the handle, drop unused codes
  est_front u_front (
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .orientation  (orientation),
    .slot_handle  (slot_handle),
    .pointer      (pointer),
    .label        (label),
    .result_limit (result_limit),
    .push         (push),
    .item         (push_item)
  );

  // queue full holds off the next transfer
  est_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .full      (busy)
  );

  // back: slot stores, scans and result register
  est_back #(.SLOTS(SLOTS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .valid           (valid),
    .offset          (offset),
    .found           (found),
    .orientation_out (orientation_out),
    .pointer_out     (pointer_out),
    .label_out       (label_out),
    .match_count     (match_count),
    .status          (status),
    .last            (last)
  );

endmodule
